// ===== hdl/agbt_pkg.sv =====
package agbt_pkg;

  localparam int MAX_RESULTS = 64;
  localparam int CNTW = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] OP_HDR    = 2'd0;
  localparam logic [1:0] OP_DATA   = 2'd1;
  localparam logic [1:0] OP_TXDONE = 2'd2;
  localparam logic [1:0] OP_RX     = 2'd3;

  localparam logic [7:0] ACK_RESET = 8'd100;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DROP,
    ST_PLAN,
    ST_READ,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic       push;
    logic [7:0] wdata;
    logic       pop;
    logic       rd_en;
  } ring_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ring_sts_t;

endpackage

// ===== hdl/agbt_ifs.sv =====
interface agbt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] msg_len;
  logic [7:0] data_byte;
  logic [7:0] rx_len;
  logic [7:0] rx_first;

  modport source (output valid, output op, output msg_len, output data_byte,
                  output rx_len, output rx_first, input ready);
  modport sink (input valid, input op, input msg_len, input data_byte,
                input rx_len, input rx_first, output ready);
endinterface

interface agbt_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] tx_byte;
  logic       block_last;

  modport source (output valid, output kind, output tx_byte, output block_last,
                  input ready);
  modport sink (input valid, input kind, input tx_byte, input block_last,
                output ready);
endinterface

// ===== hdl/agbt_ring.sv =====
module agbt_ring
  import agbt_pkg::*;
#(
  parameter int RING_DEPTH = 256,
  localparam int PW = $clog2(RING_DEPTH),
  localparam int FW = $clog2(RING_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  ring_cmd_t     cmd,
  output ring_sts_t     sts,
  output logic [FW-1:0] fill,
  output logic [7:0]    rdata
);

  logic [7:0]    mem [RING_DEPTH];
  logic [PW-1:0] write_ptr;
  logic [PW-1:0] read_ptr;
  logic [PW-1:0] write_ptr_inc;
  logic [PW-1:0] read_ptr_inc;
  logic [PW-1:0] rd_addr;
  logic [FW-1:0] fill_next;

  assign write_ptr_inc = (write_ptr == PW'(RING_DEPTH - 1)) ? '0 : write_ptr + 1'b1;
  assign read_ptr_inc  = (read_ptr == PW'(RING_DEPTH - 1)) ? '0 : read_ptr + 1'b1;

  // a pop with a read fetches the byte after the one just taken
  assign rd_addr = cmd.pop ? read_ptr_inc : read_ptr;

  always_comb begin
    fill_next = fill;
    if (cmd.push && !cmd.pop) begin
      fill_next = fill + 1'b1;
    end else if (cmd.pop && !cmd.push) begin
      fill_next = fill - 1'b1;
    end
  end

  assign sts.full  = (fill == FW'(RING_DEPTH));
  assign sts.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr <= '0;
      read_ptr  <= '0;
      fill      <= '0;
    end else begin
      fill <= fill_next;
      if (cmd.push) begin
        write_ptr <= write_ptr_inc;
      end
      if (cmd.pop) begin
        read_ptr <= read_ptr_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[write_ptr] <= cmd.wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/agbt_ctrl.sv =====
module agbt_ctrl
  import agbt_pkg::*;
#(
  parameter int RING_DEPTH = 256,
  parameter int BLOCK_BYTES = 20,
  localparam int FW = $clog2(RING_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  agbt_in_if.sink       in_ch,
  agbt_out_if.source    out_ch,
  input  logic          cfg_wr_en,
  input  logic [7:0]    cfg_wr_data,
  input  logic [FW-1:0] fill,
  input  ring_sts_t     sts,
  input  logic [7:0]    rdata,
  output ring_cmd_t     cmd
);

  localparam int CMPW = (FW > CNTW) ? FW : CNTW;
  localparam int LIM_NODROP = (BLOCK_BYTES < MAX_RESULTS) ? BLOCK_BYTES : MAX_RESULTS;
  localparam int LIM_DROP = (BLOCK_BYTES < MAX_RESULTS - 1) ? BLOCK_BYTES : MAX_RESULTS - 1;

  state_t          state, state_next;
  logic [7:0]      ack_value;
  logic [7:0]      payload_left, payload_left_next;
  logic            in_flight, in_flight_next;
  logic            block_sent, block_sent_next;
  logic            block_acked, block_acked_next;
  logic            dropped, dropped_next;
  logic            start, start_next;
  logic [CNTW-1:0] cnt, cnt_next;

  logic            accept;
  logic            done;
  logic            go;
  logic            drop;
  logic            begin_blk;
  logic [CMPW-1:0] fill_ext;
  logic [CMPW-1:0] limit;
  logic [CMPW-1:0] n;

  assign accept   = in_ch.valid && in_ch.ready;
  assign fill_ext = CMPW'(fill);
  assign limit    = dropped ? CMPW'(LIM_DROP) : CMPW'(LIM_NODROP);
  assign n        = (fill_ext < limit) ? fill_ext : limit;

  assign in_ch.ready       = (state == ST_IDLE);
  assign out_ch.valid      = (state == ST_DROP) || (state == ST_SEND);
  assign out_ch.kind       = (state == ST_DROP);
  assign out_ch.tx_byte    = (state == ST_DROP) ? 8'd0 : rdata;
  assign out_ch.block_last = (state == ST_DROP) || (cnt == CNTW'(1));

  always_comb begin
    state_next        = state;
    payload_left_next = payload_left;
    in_flight_next    = in_flight;
    block_sent_next   = block_sent;
    block_acked_next  = block_acked;
    dropped_next      = dropped;
    start_next        = start;
    cnt_next          = cnt;
    cmd               = '0;
    done              = 1'b0;
    go                = 1'b0;
    drop              = 1'b0;
    begin_blk         = 1'b0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (in_ch.op)
            OP_HDR: begin
              cmd.push          = !sts.full;
              cmd.wdata         = in_ch.msg_len;
              drop              = sts.full;
              payload_left_next = in_ch.msg_len;
              done              = (in_ch.msg_len == 8'd0);
            end
            OP_DATA: begin
              if (payload_left != 8'd0) begin
                cmd.push          = !sts.full;
                cmd.wdata         = in_ch.data_byte;
                drop              = sts.full;
                payload_left_next = payload_left - 1'b1;
                done              = (payload_left == 8'd1);
              end
            end
            OP_TXDONE: begin
              if (in_flight) begin
                block_sent_next = 1'b1;
                go              = block_acked;
              end
            end
            OP_RX: begin
              if (block_sent && in_ch.rx_len == 8'd1 && in_ch.rx_first == ack_value) begin
                block_acked_next = 1'b1;
                go               = 1'b1;
              end
            end
            default: begin
            end
          endcase

          // message complete: open a block if idle and the ring holds data
          if (done && !in_flight && (!sts.empty || cmd.push)) begin
            in_flight_next = 1'b1;
            begin_blk      = 1'b1;
          end
          // sent and acked: next block, or stop on an empty ring
          if (go) begin
            block_sent_next  = 1'b0;
            block_acked_next = 1'b0;
            if (!sts.empty) begin
              begin_blk = 1'b1;
            end else begin
              in_flight_next = 1'b0;
            end
          end

          dropped_next = drop;
          start_next   = begin_blk;
          if (drop) begin
            state_next = ST_DROP;
          end else if (begin_blk) begin
            state_next = ST_PLAN;
          end
        end
      end
      ST_DROP: begin
        if (out_ch.ready) begin
          state_next = start ? ST_PLAN : ST_IDLE;
        end
      end
      ST_PLAN: begin
        cnt_next   = n[CNTW-1:0];
        state_next = ST_READ;
      end
      ST_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_SEND;
      end
      ST_SEND: begin
        if (out_ch.ready) begin
          cmd.pop  = 1'b1;
          cnt_next = cnt - 1'b1;
          if (cnt != CNTW'(1)) begin
            cmd.rd_en = 1'b1;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      ack_value    <= ACK_RESET;
      payload_left <= '0;
      in_flight    <= 1'b0;
      block_sent   <= 1'b0;
      block_acked  <= 1'b0;
      dropped      <= 1'b0;
      start        <= 1'b0;
      cnt          <= '0;
    end else begin
      state        <= state_next;
      payload_left <= payload_left_next;
      in_flight    <= in_flight_next;
      block_sent   <= block_sent_next;
      block_acked  <= block_acked_next;
      dropped      <= dropped_next;
      start        <= start_next;
      cnt          <= cnt_next;
      if (cfg_wr_en) begin
        ack_value <= cfg_wr_data;
      end
    end
  end

endmodule

// ===== hdl/ack_gated_block_transmit_ring.sv =====
// timing: a request is accepted while the controller is idle; a drop flag shows the next cycle,
// and the first byte of a block follows the PLAN and READ states
// throughput: while the receiver is ready, a block leaves one byte per cycle
// from the ring memory's registered read port; the next request is taken
// the cycle after the last result; reset: control state and pointers clear,
// ack_value returns to 100, ring contents are not cleared
module ack_gated_block_transmit_ring
  import agbt_pkg::*;
#(
  parameter int RING_DEPTH = 256,
  parameter int BLOCK_BYTES = 20
) (
  input  logic       clk,
  input  logic       rst,
  agbt_in_if.sink    in_ch,
  agbt_out_if.source out_ch,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  localparam int FW = $clog2(RING_DEPTH + 1);

  ring_cmd_t     cmd;
  ring_sts_t     sts;
  logic [FW-1:0] fill;
  logic [7:0]    rdata;

  agbt_ring #(
    .RING_DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .sts  (sts),
    .fill (fill),
    .rdata(rdata)
  );

  agbt_ctrl #(
    .RING_DEPTH (RING_DEPTH),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .fill       (fill),
    .sts        (sts),
    .rdata      (rdata),
    .cmd        (cmd)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid))
    else $error("request taken while a result is pending");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(RING_DEPTH))
    else $error("ring fill count beyond depth");

  a_block_streams: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && !out_ch.kind && !out_ch.block_last) |=>
      (out_ch.valid && !out_ch.kind))
    else $error("block byte not followed by the next byte");

  a_no_push_on_full: assert property (@(posedge clk) disable iff (rst)
    sts.full |-> !cmd.push)
    else $error("write into a full ring");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import agbt_pkg::*;

  localparam int RING_DEPTH = 256;
  localparam int BLOCK_BYTES = 20;
  localparam int PTRW = $clog2(RING_DEPTH);
  localparam int ITEMS_PER_PHASE = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_GUARD = 400000;
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_DROP = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    logic       block_last;
  } txres_t;

  typedef struct {
    logic [1:0] op;
    logic [7:0] msg_len;
    logic [7:0] data_byte;
    logic [7:0] rx_len;
    logic [7:0] rx_first;
  } req_t;

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  agbt_in_if  in_ch ();
  agbt_out_if out_ch ();

  ack_gated_block_transmit_ring #(
    .RING_DEPTH (RING_DEPTH),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // mirror of the transmitter state
  logic [7:0]      ring_mirror [RING_DEPTH];
  logic [PTRW-1:0] rd_idx;
  logic [PTRW-1:0] wr_idx;
  logic [PTRW:0]   ring_fill;
  logic [7:0]      pay_left;
  logic            flight;
  logic            blk_sent;
  logic            blk_acked;
  logic [7:0]      ack_mirror;

  txres_t tx_expected[$];
  req_t   stim_q[$];
  req_t   next_req;
  txres_t head_res;

  int   n_offered = 0;
  int   n_accepted = 0;
  int   send_gap = 0;
  int   stall_left = 0;
  int   hold_asked = 0;
  int   hold_served = 0;
  int   mismatch_count = 0;
  int   n_results = 0;
  int   n_blocks = 0;
  int   n_drops = 0;
  logic steady = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int store_byte(input logic [7:0] b, input int used);
    if (ring_fill == RING_DEPTH) begin
      tx_expected.push_back(txres_t'{KIND_DROP, 8'h00, 1'b1});
      return used + 1;
    end
    ring_mirror[wr_idx] = b;
    wr_idx++;
    ring_fill++;
    return used;
  endfunction

  function automatic int emit_block(input int used);
    int n;
    n = int'(ring_fill);
    if (n > BLOCK_BYTES) n = BLOCK_BYTES;
    if (n > MAX_RESULTS - used) n = MAX_RESULTS - used;
    for (int i = 0; i < n; i++) begin
      tx_expected.push_back(txres_t'{KIND_BYTE, ring_mirror[rd_idx], i == n - 1});
      rd_idx++;
      ring_fill--;
    end
    return used + n;
  endfunction

  function automatic int finish_message(input int used);
    if (!flight && ring_fill != 0) begin
      flight = 1'b1;
      return emit_block(used);
    end
    return used;
  endfunction

  // next block only once both the transmit done and the acknowledge are in
  function automatic int resume_tx(input int used);
    if (blk_sent && blk_acked) begin
      blk_sent = 1'b0;
      blk_acked = 1'b0;
      if (ring_fill != 0) return emit_block(used);
      flight = 1'b0;
    end
    return used;
  endfunction

  task automatic predict_tx(input logic [1:0] op, input logic [7:0] mlen, input logic [7:0] dbyte,
                            input logic [7:0] rlen, input logic [7:0] rfirst);
    int k;
    k = 0;
    case (op)
      OP_HDR: begin
        k = store_byte(mlen, k);
        pay_left = mlen;
        if (pay_left == 0) k = finish_message(k);
      end
      OP_DATA: begin
        if (pay_left != 0) begin
          k = store_byte(dbyte, k);
          pay_left--;
          if (pay_left == 0) k = finish_message(k);
        end
      end
      OP_TXDONE: begin
        if (flight) begin
          blk_sent = 1'b1;
          k = resume_tx(k);
        end
      end
      default: begin
        if (blk_sent && rlen == 8'd1 && rfirst == ack_mirror) begin
          blk_acked = 1'b1;
          k = resume_tx(k);
        end
      end
    endcase
  endtask

  // request side
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      predict_tx(in_ch.op, in_ch.msg_len, in_ch.data_byte, in_ch.rx_len, in_ch.rx_first);
      n_accepted <= n_accepted + 1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (n_accepted == n_offered) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (stim_q.size() != 0) begin
        next_req = stim_q.pop_front();
        in_ch.op <= next_req.op;
        in_ch.msg_len <= next_req.msg_len;
        in_ch.data_byte <= next_req.data_byte;
        in_ch.rx_len <= next_req.rx_len;
        in_ch.rx_first <= next_req.rx_first;
        in_ch.valid <= 1'b1;
        n_offered <= n_offered + 1;
        send_gap <= pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result side
  always @(negedge clk) begin
    if (hold_asked != hold_served) begin
      hold_served <= hold_asked;
      stall_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (tx_expected.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: kind %0b byte %02h last %0b",
                                  out_ch.kind, out_ch.tx_byte, out_ch.block_last));
      end else begin
        head_res = tx_expected.pop_front();
        if (out_ch.kind !== head_res.kind)
          report_mismatch($sformatf("kind %0b, expected %0b", out_ch.kind, head_res.kind));
        if (out_ch.tx_byte !== head_res.tx_byte)
          report_mismatch($sformatf("tx_byte %02h, expected %02h", out_ch.tx_byte,
                                    head_res.tx_byte));
        if (out_ch.block_last !== head_res.block_last)
          report_mismatch($sformatf("block_last %0b, expected %0b", out_ch.block_last,
                                    head_res.block_last));
        n_results++;
        if (head_res.kind == KIND_DROP) n_drops++;
        else if (head_res.block_last) n_blocks++;
      end
    end
  end

  task automatic queue_req(input logic [1:0] op, input logic [7:0] mlen, input logic [7:0] dbyte,
                           input logic [7:0] rlen, input logic [7:0] rfirst);
    req_t r;
    r.op = op;
    r.msg_len = mlen;
    r.data_byte = dbyte;
    r.rx_len = rlen;
    r.rx_first = rfirst;
    stim_q.push_back(r);
  endtask

  // header of len, then npay payload bytes; unused fields carry noise
  task automatic queue_msg(input int len, input int npay);
    queue_req(OP_HDR, 8'(len), rnd8(), rnd8(), rnd8());
    repeat (npay)
      queue_req(OP_DATA, rnd8(), rnd8(), rnd8(), rnd8());
  endtask

  task automatic queue_ack(input logic [7:0] v);
    queue_req(OP_TXDONE, rnd8(), rnd8(), rnd8(), rnd8());
    queue_req(OP_RX, rnd8(), rnd8(), 8'd1, v);
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    while ((stim_q.size() != 0 || n_accepted != n_offered || tx_expected.size() != 0)
           && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    // requests that cause no result may still be in progress
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_ack(input logic [7:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    ack_mirror = v;
  endtask

  initial begin
    int r;
    int len;
    int npay;
    int counted;
    logic [7:0] v;

    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 8'h00;
    in_ch.valid = 1'b0;
    in_ch.op = OP_HDR;
    in_ch.msg_len = 8'h00;
    in_ch.data_byte = 8'h00;
    in_ch.rx_len = 8'h00;
    in_ch.rx_first = 8'h00;
    out_ch.ready = 1'b0;
    ack_mirror = ACK_RESET;
    rd_idx = '0;
    wr_idx = '0;
    ring_fill = '0;
    pay_left = 8'h00;
    flight = 1'b0;
    blk_sent = 1'b0;
    blk_acked = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, reset acknowledge value
    queue_req(OP_RX, 8'h00, 8'h00, 8'd1, ACK_RESET);       // ack while idle
    queue_req(OP_TXDONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);      // transmit done while idle
    queue_req(OP_DATA, 8'h00, 8'hFF, 8'h00, 8'h00);        // payload with no message open
    queue_req(OP_HDR, 8'h00, 8'hFF, 8'hFF, 8'hFF);         // empty message starts a block
    queue_req(OP_RX, 8'h00, 8'h00, 8'd1, ACK_RESET);       // ack ahead of transmit done
    queue_req(OP_TXDONE, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_req(OP_RX, 8'h00, 8'h00, 8'd2, ACK_RESET);       // wrong packet length
    queue_req(OP_RX, 8'h00, 8'h00, 8'd1, ACK_RESET - 8'd1);
    queue_req(OP_RX, 8'h00, 8'h00, 8'd1, ACK_RESET);       // ring empty, sending stops
    queue_req(OP_HDR, 8'd3, 8'h00, 8'h00, 8'h00);
    queue_req(OP_DATA, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_req(OP_HDR, 8'd2, 8'h00, 8'h00, 8'h00);          // new header mid message
    queue_req(OP_DATA, 8'h00, 8'hFF, 8'h00, 8'h00);
    queue_req(OP_DATA, 8'h00, 8'h80, 8'h00, 8'h00);
    queue_req(OP_TXDONE, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_req(OP_RX, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_req(OP_RX, 8'h00, 8'h00, 8'd1, ACK_RESET);
    queue_req(OP_TXDONE, 8'h00, 8'h00, 8'h00, 8'h00);      // idle again
    wait_idle();

    // fill the ring while idle; the byte that completes the message is dropped
    // and the first block goes out on the same request
    v = 8'hFF;
    write_ack(v);
    queue_msg(255, 254);
    queue_msg(1, 1);
    wait_idle();

    // receiver holds off while the sender keeps pushing acknowledges
    steady = 1'b1;
    hold_asked++;
    repeat (13) queue_ack(v);
    wait_idle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: v = 8'h00;
        2: v = ACK_RESET;
        default: v = rnd8();
      endcase
      steady = (phase == 2);
      write_ack(v);
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          r = $urandom_range(0, 99);
          len = (r < 70) ? $urandom_range(0, 6) :
                (r < 95) ? $urandom_range(7, 30) : $urandom_range(31, 120);
          queue_msg(len, len);
          counted += len + 1;
        end else if (r < 78) begin
          queue_ack(v);
          counted += 2;
        end else if (r < 86) begin
          // message cut short by the next header
          len = $urandom_range(2, 12);
          npay = $urandom_range(0, len - 1);
          queue_msg(len, npay);
          counted += npay + 1;
        end else if (r < 93) begin
          queue_req(OP_TXDONE, rnd8(), rnd8(), rnd8(), rnd8());
          if ($urandom_range(0, 1))
            queue_req(OP_RX, rnd8(), rnd8(), 8'($urandom_range(2, 255)), v);
          else
            queue_req(OP_RX, rnd8(), rnd8(), 8'd1, v ^ 8'($urandom_range(1, 255)));
          counted += 2;
        end else begin
          queue_req(2'($urandom_range(0, 3)), rnd8(), rnd8(), rnd8(), rnd8());
          counted += 1;
        end
      end
      wait_idle();
    end

    // empty the ring
    repeat (16) queue_ack(v);
    wait_idle();

    if (stim_q.size() != 0 || n_accepted != n_offered)
      report_mismatch($sformatf("%0d requests never taken", stim_q.size() + n_offered - n_accepted));
    if (tx_expected.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", tx_expected.size()));

    $display("run covered %0d requests and %0d results: %0d blocks, %0d ring-full drops",
             n_accepted, n_results, n_blocks, n_drops);
    $display("acknowledge byte set to 100, 255, 0 and random values; one long receiver hold");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout after %0t", $time);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/agbt_pkg.sv
hdl/agbt_ifs.sv
hdl/agbt_ring.sv
hdl/agbt_ctrl.sv
hdl/ack_gated_block_transmit_ring.sv
verif/testbench.sv
